>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned Tables       = 8;
  localparam int unsigned PointsPerTbl = 64;
  localparam int unsigned ValueBits    = 32;
  localparam int unsigned TidW         = 3;
  localparam int unsigned PidxW        = 6;
  localparam int unsigned AddrW        = TidW + PidxW;
  localparam int unsigned LenW         = PidxW + 1;
  localparam int unsigned DivW         = 64;

  typedef enum logic [0:0] {
    ActLoad  = 1'b0,
    ActQuery = 1'b1
  } action_e;

  typedef struct packed {
    logic                        action;
    logic [TidW-1:0]             table_id;
    logic [PidxW-1:0]            point_index;
    logic signed [ValueBits-1:0] knot_x;
    logic signed [ValueBits-1:0] knot_y;
    logic                        is_last_point;
    logic signed [ValueBits-1:0] query_time;
  } in_word_t;

  typedef struct packed {
    logic [TidW-1:0]             result_table;
    logic signed [ValueBits-1:0] value;
    logic                        empty_table;
    logic                        last_result;
  } out_word_t;

  // divider request / response
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [32:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/pli_if.sv
// ----------------------------------------------------------------------------
// pli_in_if / pli_out_if / pli_cfg_if
// Valid-ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
interface pli_in_if;
  logic             valid;
  logic             ready;
  pli_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pli_out_if;
  logic              valid;
  logic              ready;
  pli_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pli_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/pli_divider.sv
// ----------------------------------------------------------------------------
// pli_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pli_pkg::div_req_t req_i,
  output pli_pkg::div_rsp_t rsp_o
);
  import pli_pkg::*;

  logic [DivW-1:0] num_q, num_d;
  logic [33:0]     rem_q, rem_d;
  logic [32:0]     den_q, den_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [33:0]     shifted;
  logic [34:0]     diff;

  always_comb begin
    shifted = {rem_q[32:0], num_q[DivW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift into the low end of the dividend register
      if (!diff[34]) begin
        rem_d = diff[33:0];
        num_d = {num_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;
endmodule

>>> rtl/core/pli_multiplier.sv
// ----------------------------------------------------------------------------
// pli_multiplier
// Shift-and-add multiplier: 33 x 33 unsigned, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pli_multiplier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic        done_o,
  output logic [65:0] prod_o
);
  import pli_pkg::*;

  logic [65:0] acc_q, acc_d;
  logic [32:0] a_q, a_d;
  logic [32:0] b_q, b_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] sum;

  always_comb begin
    sum    = {1'b0, acc_q[65:33]} + (b_q[0] ? {1'b0, a_q} : 34'd0);
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add partial product to the top half, then shift right one bit
      acc_d = {sum, acc_q[32:1]};
      b_d   = {1'b0, b_q[32:1]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

>>> rtl/core/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Clamped piecewise linear interpolation over eight breakpoint tables.
// ----------------------------------------------------------------------------
// Load: written into the knot memories; no result word.
// Query: per table that is neither empty nor clamped, a linear segment scan
//   (up to 2 memory reads per point), a serial multiply and a serial divide;
//   one table after another.
// One word is in flight at a time; input is ready only in idle, and a table
//   starts only once the previous result word has been taken.
// Reset clears table lengths and sets tables_in_use to 1; knot memories
//   keep undefined contents until loaded.
module piecewise_linear_interpolator (
  input  logic      clk_i,
  input  logic      rst_ni,
  pli_in_if.sink    in_if,
  pli_out_if.source out_if,
  pli_cfg_if.sink   cfg_if
);
  import pli_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StFirst = 9'b000000010,
    StLast  = 9'b000000100,
    StScan  = 9'b000001000,
    StNext  = 9'b000010000,
    StMul   = 9'b000100000,
    StDiv   = 9'b001000000,
    StOut   = 9'b010000000,
    StWait  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // knot memories
  logic signed [ValueBits-1:0] xmem [Tables*PointsPerTbl];
  logic signed [ValueBits-1:0] ymem [Tables*PointsPerTbl];
  logic signed [ValueBits-1:0] xrd_q, yrd_q;
  logic [AddrW-1:0]            raddr;
  logic [LenW-1:0]             len_q [Tables];

  logic [3:0]  tiu_q;
  logic [TidW-1:0] tbl_q, tbl_d;
  logic [3:0]  ntab;
  logic [PidxW-1:0] idx_q, idx_d;
  logic signed [ValueBits-1:0] qt_q, x0_q, x0_d, y0_q, y0_d;
  logic        rd_ph_q, rd_ph_d;
  logic        neg_q, neg_d;
  logic [32:0] dx_q, dx_d;
  out_word_t   ow_q, ow_d;
  logic        ov_q, ov_d;
  logic        mstart, mdone;
  logic [32:0] ma, mb;
  logic [65:0] prod;
  logic [65:0] prod_q, prod_d;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic signed [32:0] dy, qd;
  logic        in_acc;
  logic [LenW-1:0] curlen;
  logic [PidxW-1:0] lastidx;

  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_q == StIdle) && !ov_q;
  assign cfg_if.ready = 1'b1;
  assign ntab = (tiu_q == 4'd0) ? 4'd1 : ((tiu_q > 4'(Tables)) ? 4'(Tables) : tiu_q);
  assign curlen  = len_q[tbl_q];
  assign lastidx = PidxW'(curlen - LenW'(1));

  // knot writes and registered reads
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.data.action == ActLoad) begin
      xmem[{in_if.data.table_id, in_if.data.point_index}] <= in_if.data.knot_x;
      ymem[{in_if.data.table_id, in_if.data.point_index}] <= in_if.data.knot_y;
    end
    xrd_q <= xmem[raddr];
    yrd_q <= ymem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Tables; i++) len_q[i] <= '0;
      tiu_q <= 4'd1;
    end else begin
      if (in_acc && in_if.data.action == ActLoad && in_if.data.is_last_point)
        len_q[in_if.data.table_id] <= LenW'(in_if.data.point_index) + LenW'(1);
      if (cfg_if.valid) tiu_q <= cfg_if.data;
    end
  end

  pli_multiplier u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
    .done_o(mdone), .prod_o(prod)
  );

  pli_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // sequencer
  always_comb begin
    state_d = state_q;
    tbl_d   = tbl_q;
    idx_d   = idx_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    rd_ph_d = rd_ph_q;
    neg_d   = neg_q;
    dx_d    = dx_q;
    ow_d    = ow_q;
    ov_d    = ov_q;
    prod_d  = prod_q;
    raddr   = {tbl_q, idx_q};
    mstart  = 1'b0;
    dy      = 33'(yrd_q) - 33'(y0_q);
    qd      = 33'(qt_q) - 33'(x0_q);
    ma      = dy[32] ? 33'(-dy) : dy;
    mb      = qd;
    dreq.start    = 1'b0;
    dreq.dividend = prod_q[DivW-1:0];
    dreq.divisor  = dx_q;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc && in_if.data.action == ActQuery) begin
          tbl_d   = '0;
          state_d = StFirst;
          idx_d   = '0;
          rd_ph_d = 1'b0;
        end
      end
      StFirst: begin
        // read point 0, then test low clamp; the result word is held until taken
        raddr = {tbl_q, PidxW'(0)};
        if (!ov_q) begin
          ow_d.result_table = tbl_q;
          ow_d.last_result  = (4'(tbl_q) + 4'd1 == ntab);
          ow_d.empty_table  = 1'b0;
          if (curlen == '0) begin
            ow_d.empty_table = 1'b1;
            ow_d.value       = '0;
            state_d          = StOut;
          end else if (rd_ph_q) begin
            rd_ph_d = 1'b0;
            if (qt_q < xrd_q) begin
              ow_d.value = yrd_q;
              state_d    = StOut;
            end else begin
              raddr   = {tbl_q, lastidx};
              state_d = StLast;
            end
          end else rd_ph_d = 1'b1;
        end
      end
      StLast: begin
        raddr = {tbl_q, lastidx};
        if (rd_ph_q) begin
          rd_ph_d = 1'b0;
          if (qt_q >= xrd_q) begin
            ow_d.value = yrd_q;
            state_d    = StOut;
          end else begin
            idx_d   = '0;
            state_d = StScan;
          end
        end else rd_ph_d = 1'b1;
      end
      StScan: begin
        // read point i as segment start
        if (rd_ph_q) begin
          rd_ph_d = 1'b0;
          x0_d    = xrd_q;
          y0_d    = yrd_q;
          idx_d   = idx_q + PidxW'(1);
          state_d = StNext;
        end else rd_ph_d = 1'b1;
      end
      StNext: begin
        // read point i+1; test segment
        if (rd_ph_q) begin
          rd_ph_d = 1'b0;
          if (x0_q <= qt_q && qt_q < xrd_q) begin
            neg_d   = dy[32];
            dx_d    = 33'(xrd_q) - 33'(x0_q);
            mstart  = 1'b1;
            state_d = StMul;
          end else begin
            // slide: point i+1 becomes new start
            x0_d  = xrd_q;
            y0_d  = yrd_q;
            idx_d = idx_q + PidxW'(1);
          end
        end else rd_ph_d = 1'b1;
      end
      StMul: begin
        if (mdone) begin
          prod_d  = prod;
          state_d = StWait;
        end
      end
      StWait: begin
        dreq.start = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        if (drsp.done) begin
          ow_d.value = neg_q ? ValueBits'(y0_q - ValueBits'(drsp.quotient))
                             : ValueBits'(y0_q + ValueBits'(drsp.quotient));
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ov_q) begin
          ov_d  = 1'b1;
          idx_d = '0;
          if (ow_q.last_result) state_d = StIdle;
          else begin
            tbl_d   = tbl_q + TidW'(1);
            state_d = StFirst;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      rd_ph_q <= 1'b0;
      tbl_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      rd_ph_q <= rd_ph_d;
      tbl_q   <= tbl_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) qt_q <= in_if.data.query_time;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    neg_q  <= neg_d;
    dx_q   <= dx_d;
    ow_q   <= ow_d;
    prod_q <= prod_d;
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = ow_q;
endmodule

>>> verif/tb_piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Self-checking testbench for the clamped piecewise linear interpolator.
// Breakpoint tables are loaded through the input channel. Each query is
// predicted table by table, and every result word is compared field by field
// with the oldest prediction. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;
  import pli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 10000000;
  localparam int unsigned DrainWait  = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pli_in_if  in_if ();
  pli_out_if out_if ();
  pli_cfg_if cfg_if ();

  piecewise_linear_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the block's tables and register
  logic signed [31:0] bp_x [Tables][PointsPerTbl];
  logic signed [31:0] bp_y [Tables][PointsPerTbl];
  bit                 bp_written [Tables][PointsPerTbl];
  int unsigned        bp_len [Tables];
  logic [3:0]         active_tables;

  out_word_t   pending_results [$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  int unsigned sink_stall = 0;

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // clamped segment interpolation for one table
  function automatic logic signed [31:0] interp_table(int unsigned t,
                                                      logic signed [31:0] q);
    int unsigned        last;
    longint             y0, y1, dy, dq, span, f;
    logic [65:0]        prod;
    last = bp_len[t] - 1;
    if (q < bp_x[t][0]) return bp_y[t][0];
    if (q >= bp_x[t][last]) return bp_y[t][last];
    for (int unsigned i = 0; i < last; i++) begin
      if (bp_x[t][i] <= q && q < bp_x[t][i+1]) begin
        y0   = bp_y[t][i];
        y1   = bp_y[t][i+1];
        dy   = y1 - y0;
        dq   = longint'(q) - longint'(bp_x[t][i]);
        span = longint'(bp_x[t][i+1]) - longint'(bp_x[t][i]);
        prod = 66'(dy < 0 ? -dy : dy) * 66'(dq);
        f    = longint'(prod / 66'(span));
        return (dy < 0) ? 32'(y0 - f) : 32'(y0 + f);
      end
    end
    return bp_y[t][last];
  endfunction

  // update the shadow state for one accepted word
  task automatic apply_word(input in_word_t w);
    int unsigned n;
    out_word_t   r;
    if (w.action == ActLoad) begin
      bp_x[w.table_id][w.point_index] = w.knot_x;
      bp_y[w.table_id][w.point_index] = w.knot_y;
      bp_written[w.table_id][w.point_index] = 1'b1;
      if (w.is_last_point) bp_len[w.table_id] = w.point_index + 1;
    end else begin
      n = (active_tables == 0) ? 1 : (active_tables > Tables ? Tables : active_tables);
      for (int unsigned t = 0; t < n; t++) begin
        r.result_table = t[TidW-1:0];
        r.empty_table  = (bp_len[t] == 0);
        r.value        = r.empty_table ? '0 : interp_table(t, w.query_time);
        r.last_result  = (t + 1 == n);
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic send_word(input in_word_t w);
    int unsigned g;
    g = idle_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    apply_word(w);
    words_sent++;
  endtask

  task automatic send_load(input int unsigned t, input int unsigned p,
                           input logic [31:0] x, input logic [31:0] y,
                           input bit last);
    in_word_t w;
    w = '0;
    w.action        = ActLoad;
    w.table_id      = t[TidW-1:0];
    w.point_index   = p[PidxW-1:0];
    w.knot_x        = x;
    w.knot_y        = y;
    w.is_last_point = last;
    w.query_time    = $urandom();
    send_word(w);
  endtask

  task automatic send_query(input logic [31:0] q);
    in_word_t w;
    w = '0;
    w.table_id      = TidW'($urandom());
    w.point_index   = PidxW'($urandom());
    w.is_last_point = 1'($urandom());
    w.knot_x        = $urandom();
    w.knot_y        = $urandom();
    w.action        = ActQuery;
    w.query_time    = q;
    send_word(w);
  endtask

  // hold the sender until every expected word is back and the block is idle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_active_tables(input logic [3:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    active_tables = v;
    cfg_if.valid <= 1'b0;
  endtask

  // load a well-formed table of n points, ascending unless scrambled
  task automatic load_table(input int unsigned t, input int unsigned n,
                            input bit scrambled);
    int xs [$];
    for (int unsigned i = 0; i < n; i++) xs.push_back(int'($urandom()));
    if (!scrambled) xs.sort();
    for (int unsigned i = 0; i < n; i++)
      send_load(t, i, xs[i], $urandom(), i == n - 1);
  endtask

  // query near a stored breakpoint, between two, or anywhere
  function automatic logic [31:0] pick_query();
    int unsigned t, i, r;
    r = $urandom_range(0, 9);
    t = $urandom_range(0, Tables - 1);
    if (r < 2 || bp_len[t] == 0) return $urandom();
    i = $urandom_range(0, bp_len[t] - 1);
    if (r < 6) return bp_x[t][i] + $signed($urandom_range(0, 6)) - 3;
    return bp_x[t][i] + $signed($urandom_range(0, 200000)) - 100000;
  endfunction

  // directed corners: empty tables, value extremes, clamps, odd register values
  task automatic test_directed();
    send_query(32'h8000_0000);
    send_load(0, 0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_load(0, 1, 32'h0000_0000, 32'h8000_0000, 1'b0);
    send_load(0, 2, 32'h7fff_ffff, 32'h0000_0000, 1'b1);
    send_query(32'h8000_0000);
    send_query(32'h7fff_ffff);
    send_query(32'hffff_ffff);
    send_query(32'h0000_0005);
    send_load(1, 0, 32'd100, 32'hffff_0000, 1'b0);
    send_load(1, 1, 32'd300, 32'h0001_0000, 1'b1);
    write_active_tables(4'd2);
    send_query(32'd99);
    send_query(32'd201);
    // unordered table: lowest matching segment wins
    send_load(2, 0, 32'd0, 32'd10, 1'b0);
    send_load(2, 1, 32'd100, 32'd1000, 1'b0);
    send_load(2, 2, 32'd50, 32'd7, 1'b0);
    send_load(2, 3, 32'd200, 32'hffff_fff0, 1'b1);
    write_active_tables(4'd15);
    send_query(32'd75);
    send_query(32'd120);
    // shorten table 2 by marking an earlier point as the last
    send_load(2, 1, 32'd100, 32'd1000, 1'b1);
    send_query(32'd120);
    write_active_tables(4'd0);
    send_query(32'd40);
  endtask

  // register values 0 to 9 and 15 in turn, with a full table set
  task automatic test_register_sweep();
    for (int unsigned t = 0; t < Tables; t++)
      load_table(t, $urandom_range(1, 5), 1'b0);
    load_table(7, PointsPerTbl, 1'b0);
    for (int v = 0; v < 16; v += ((v < 9) ? 1 : 6)) begin
      write_active_tables(v[3:0]);
      send_query(pick_query());
      send_query(pick_query());
    end
  endtask

  // random tables, noise loads, queries, register writes and drains until the word budget is used
  task automatic test_random();
    int unsigned r, t, p;
    bit          ok;
    while (words_sent < 470) begin
      r = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 19) == 0) ? ~no_idle : no_idle;
      if (r < 3) begin
        write_active_tables($urandom_range(0, 15));
      end else if (r < 5) begin
        drain();
      end else if (r < 20) begin
        t = $urandom_range(0, Tables - 1);
        load_table(t, ($urandom_range(0, 29) == 0) ? PointsPerTbl : $urandom_range(1, 8),
                   $urandom_range(0, 6) == 0);
      end else if (r < 30) begin
        t = $urandom_range(0, Tables - 1);
        p = $urandom_range(0, PointsPerTbl - 1);
        ok = 1'b1;
        for (int unsigned i = 0; i < p; i++) ok &= bp_written[t][i];
        send_load(t, p, $urandom(), $urandom(), ok && $urandom_range(0, 1));
      end else begin
        send_query(pick_query());
      end
    end
    no_idle = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: table %0d value %0d",
               out_if.data.result_table, out_if.data.value);
        fail_count++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_if.data.result_table !== exp_w.result_table) begin
          $error("result_table: expected %0d, got %0d",
                 exp_w.result_table, out_if.data.result_table);
          fail_count++;
        end
        if (out_if.data.value !== exp_w.value) begin
          $error("value: expected %0d, got %0d", exp_w.value, out_if.data.value);
          fail_count++;
        end
        if (out_if.data.empty_table !== exp_w.empty_table) begin
          $error("empty_table: expected %0d, got %0d",
                 exp_w.empty_table, out_if.data.empty_table);
          fail_count++;
        end
        if (out_if.data.last_result !== exp_w.last_result) begin
          $error("last_result: expected %0d, got %0d",
                 exp_w.last_result, out_if.data.last_result);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      out_if.ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) sink_stall <= idle_gap();
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("piecewise_linear_interpolator verification failed");
      $finish;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    active_tables = 4'd1;
    foreach (bp_len[t]) bp_len[t] = 0;
    foreach (bp_written[t, i]) bp_written[t][i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("piecewise_linear_interpolator verification clean");
    end else begin
      $display("piecewise_linear_interpolator verification failed");
    end
    $finish;
  end

endmodule
